// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in next-cycle check");

`endif

// ===== hdl/sba_pkg.sv =====
// Package with the types, constants and helpers of the sector bitmap allocator.
`default_nettype none

package sba_pkg;

    // Geometry of the bitmap. The word size must be a power of two and a
    // multiple of eight.
    localparam int TOTAL_SECTORS    = 8192;
    localparam int BITMAP_WORD_BITS = 64;
    localparam int NUM_WORDS =
        (TOTAL_SECTORS + BITMAP_WORD_BITS - 1) / BITMAP_WORD_BITS;
    localparam int LAST_BITS = TOTAL_SECTORS - (NUM_WORDS - 1) * BITMAP_WORD_BITS;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(BITMAP_WORD_BITS);
    localparam int SEC_W     = 13;

    // Group size used by the lowest-free-bit search.
    localparam int GRP_BITS = 8;
    localparam int NUM_GRPS = BITMAP_WORD_BITS / GRP_BITS;
    localparam int GSEL_W   = (NUM_GRPS > 1) ? $clog2(NUM_GRPS) : 1;

    typedef logic [BITMAP_WORD_BITS-1:0] t_word;
    typedef logic [WIDX_W-1:0]           t_widx;
    typedef logic [BIT_W-1:0]            t_bidx;
    typedef logic [SEC_W-1:0]            t_sector;
    typedef logic [1:0]                  t_func;
    typedef logic [1:0]                  t_status;

    // Operation codes.
    localparam t_func FN_ALLOC = 2'd0;
    localparam t_func FN_MARK  = 2'd1;
    localparam t_func FN_FREE  = 2'd2;

    // Status codes.
    localparam t_status ST_OK           = 2'd0;
    localparam t_status ST_NO_FREE      = 2'd1;
    localparam t_status ST_ALREADY_USED = 2'd2;
    localparam t_status ST_ALREADY_FREE = 2'd3;

    localparam t_widx LAST_WORD = t_widx'(NUM_WORDS - 1);

    // Request from the sequencer to the bitmap memory.
    typedef struct packed {
        logic  rd_en;
        t_widx rd_addr;
        logic  wr_en;
        t_widx wr_addr;
        t_word wr_data;
    } t_ram_req;

    // Result of the lowest-free-bit search.
    typedef struct packed {
        logic  found;
        t_bidx idx;
    } t_find;

    // One finished result.
    typedef struct packed {
        t_sector sector;
        t_status status;
    } t_result;

    // Bits of the last word that lie beyond the last sector read as used.
    function automatic t_word pad_mask();
        t_word m;
        m = '0;
        for (int i = 0; i < BITMAP_WORD_BITS; i++) begin
            if (i >= LAST_BITS) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam t_word PAD_MASK = pad_mask();

endpackage

`default_nettype wire

// ===== hdl/sba_find.sv =====
// Lowest-free-bit search over one bitmap word, done in two narrow levels.
`default_nettype none

module sba_find
    import sba_pkg::*;
(
    input  wire t_word i_word,
    output t_find      o_find
);

    logic [NUM_GRPS-1:0] grp_free;
    logic [GSEL_W-1:0]   grp_sel;
    logic [GRP_BITS-1:0] grp_byte;
    logic [2:0]          bit_sel;

    // A group holds a free sector when not all of its bits are set.
    always_comb begin
        for (int g = 0; g < NUM_GRPS; g++) begin
            grp_free[g] = ~&i_word[g*GRP_BITS +: GRP_BITS];
        end
    end

    // Pick the lowest group with a free bit.
    always_comb begin
        grp_sel = '0;
        for (int g = NUM_GRPS - 1; g >= 0; g--) begin
            if (grp_free[g]) begin
                grp_sel = GSEL_W'(g);
            end
        end
    end

    // Pick the lowest free bit inside that group.
    always_comb begin
        grp_byte = i_word[grp_sel*GRP_BITS +: GRP_BITS];
        bit_sel  = '0;
        for (int b = GRP_BITS - 1; b >= 0; b--) begin
            if (!grp_byte[b]) begin
                bit_sel = 3'(b);
            end
        end
    end

    assign o_find.found = |grp_free;
    assign o_find.idx   = BIT_W'(32'(grp_sel) * GRP_BITS + 32'(bit_sel));

endmodule

`default_nettype wire

// ===== hdl/sba_bitmap_ram.sv =====
// Bitmap memory with one read and one write port and a valid bit per word.
`default_nettype none

module sba_bitmap_ram
    import sba_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire t_ram_req i_req,
    output t_word        o_rd_data
);

    t_word                mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_row_vld;
    t_word                r_rd_data;
    logic                 r_rd_vld;

    // Word storage and registered read.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    // A word that was never written reads as all free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_row_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_row_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== hdl/sba_seq.sv =====
// Sequencer that drives the bitmap memory and the search unit.
`default_nettype none

module sba_seq
    import sba_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_req_valid,
    output logic         o_req_ready,
    input  wire t_func   i_func,
    input  wire t_sector i_sector,
    output t_ram_req     o_ram,
    input  wire t_word   i_rd_data,
    output logic         o_res_valid,
    input  wire          i_res_ready,
    output t_result      o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_FIN
    } t_state;

    t_state  r_state,  n_state;
    t_func   r_func,   n_func;
    t_sector r_sector, n_sector;
    t_widx   r_ev_addr, n_ev_addr;
    t_result r_res,    n_res;

    t_word   scan_word;
    t_find   found;
    t_bidx   chk_bit;
    t_word   chk_mask;
    logic    in_range;

    // Words of the scan, with the tail of the last word marked used.
    assign scan_word = i_rd_data | ((r_ev_addr == LAST_WORD) ? PAD_MASK : '0);

    sba_find u_find (
        .i_word (scan_word),
        .o_find (found)
    );

    assign chk_bit  = r_sector[BIT_W-1:0];
    assign chk_mask = t_word'(1) << chk_bit;
    assign in_range = 32'(i_sector) < TOTAL_SECTORS;

    // Next state, memory requests and results.
    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_sector  = r_sector;
        n_ev_addr = r_ev_addr;
        n_res     = r_res;
        o_ram     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_func   = i_func;
                    n_sector = i_sector;
                    unique case (i_func)
                        FN_ALLOC: begin
                            o_ram.rd_en   = 1'b1;
                            o_ram.rd_addr = '0;
                            n_ev_addr     = '0;
                            n_state       = S_SCAN;
                        end
                        FN_MARK, FN_FREE: begin
                            if (in_range) begin
                                o_ram.rd_en   = 1'b1;
                                o_ram.rd_addr = t_widx'(i_sector >> BIT_W);
                                n_state       = S_CHECK;
                            end else begin
                                n_res.sector = i_sector;
                                n_res.status = (i_func == FN_MARK) ?
                                               ST_ALREADY_USED : ST_ALREADY_FREE;
                                n_state      = S_FIN;
                            end
                        end
                        default: begin
                            n_res.sector = i_sector;
                            n_res.status = ST_OK;
                            n_state      = S_FIN;
                        end
                    endcase
                end
            end

            // One word is checked per cycle while the next one is read.
            S_SCAN: begin
                if (found.found) begin
                    o_ram.wr_en   = 1'b1;
                    o_ram.wr_addr = r_ev_addr;
                    o_ram.wr_data = i_rd_data | (t_word'(1) << found.idx);
                    n_res.sector  = t_sector'({r_ev_addr, found.idx});
                    n_res.status  = ST_OK;
                    n_state       = S_FIN;
                end else if (r_ev_addr == LAST_WORD) begin
                    n_res.sector = '0;
                    n_res.status = ST_NO_FREE;
                    n_state      = S_FIN;
                end else begin
                    o_ram.rd_en   = 1'b1;
                    o_ram.rd_addr = r_ev_addr + t_widx'(1);
                    n_ev_addr     = r_ev_addr + t_widx'(1);
                end
            end

            // Read-modify-write of one bit for mark and free.
            S_CHECK: begin
                n_res.sector  = r_sector;
                n_res.status  = ST_OK;
                o_ram.wr_addr = t_widx'(r_sector >> BIT_W);
                if (r_func == FN_MARK) begin
                    if (|(i_rd_data & chk_mask)) begin
                        n_res.status = ST_ALREADY_USED;
                    end else begin
                        o_ram.wr_en   = 1'b1;
                        o_ram.wr_data = i_rd_data | chk_mask;
                    end
                end else begin
                    if (!(|(i_rd_data & chk_mask))) begin
                        n_res.status = ST_ALREADY_FREE;
                    end else begin
                        o_ram.wr_en   = 1'b1;
                        o_ram.wr_data = i_rd_data & ~chk_mask;
                    end
                end
                n_state = S_FIN;
            end

            S_FIN: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_func    <= n_func;
        r_sector  <= n_sector;
        r_ev_addr <= n_ev_addr;
        r_res     <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN);
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ===== hdl/sector_bitmap_allocator.sv =====
// Top level of the first-fit sector bitmap allocator.
//
//   Channel   Dir  tdata                    tuser
//   s_axis    in   [12:0] sector_number     [1:0] func
//   m_axis    out  [12:0] result_sector     [1:0] status
//
// Allocate reads word 0, scans words up to the first free bit or the last
// word, and finishes; the bitmap memory delivers one word per cycle to the
// search. Mark and free read, then check and write, then finish.
// Reset is synchronous and active low; it clears the word valid bits, so the
// whole bitmap reads as free at once with no clearing pass.
// The result sits in an output register; the next request is taken while it
// waits, and a stalled output holds the sequencer in its finish cycle.
`default_nettype none

module sector_bitmap_allocator
    import sba_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [15:0] i_s_axis_tdata,   // [12:0] sector_number
    input  wire  [1:0]  i_s_axis_tuser,   // [1:0] func
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [12:0] result_sector
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    t_ram_req ram_req;
    t_word    rd_data;
    logic     res_valid;
    logic     res_ready;
    t_result  res;

    logic     r_out_valid;
    t_result  r_out;

    sba_bitmap_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    sba_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_func      (i_s_axis_tuser),
        .i_sector    (i_s_axis_tdata[SEC_W-1:0]),
        .o_ram       (ram_req),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Output register: loads when empty or when its beat is taken.
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = 16'(r_out.sector);
    assign o_m_axis_tuser  = r_out.status;

endmodule

`default_nettype wire

// ===== hdl/sba_checker.sv =====
// Port-level checker for the sector bitmap allocator and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module sba_checker
    import sba_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_axis_tvalid,
    input wire        o_s_axis_tready,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [15:0] o_m_axis_tdata,
    input wire [1:0]  o_m_axis_tuser
);

    logic        in_beat;
    logic        out_stall;
    logic        out_no_free;
    logic [17:0] out_word;

    assign in_beat     = i_s_axis_tvalid && o_s_axis_tready;
    assign out_stall   = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_no_free = o_m_axis_tvalid && (o_m_axis_tuser == ST_NO_FREE);
    assign out_word    = {o_m_axis_tuser, o_m_axis_tdata};

    // A stalled result beat stays put.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_axis_tvalid && $stable(out_word))

    // One request at a time: after a beat is taken the input side closes.
    `ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_beat, !o_s_axis_tready)

    // A full bitmap reports sector zero.
    `ASSERT_SAME(a_no_free_zero, i_clk, i_rst_n, out_no_free, o_m_axis_tdata == 16'd0)

    // Coming out of reset the block is empty and ready.
    `ASSERT_SAME(a_reset_idle, i_clk, i_rst_n, !$past(i_rst_n), !o_m_axis_tvalid && o_s_axis_tready)

endmodule

bind sector_bitmap_allocator sba_checker u_sba_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_sector_bitmap_allocator.sv =====
// Self-checking testbench for the first-fit sector bitmap allocator.
`timescale 1ns / 1ps

module tb_sector_bitmap_allocator;
    import sba_pkg::*;

    // The unused operation code, which the block treats as a no-op.
    localparam t_func FN_NOP = 2'd3;

    localparam int N_DIRECTED     = 22;
    localparam int N_RANDOM_A     = 200;
    localparam int N_RANDOM_B     = 100;
    localparam int N_RANDOM_C     = 100;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    // One row of the directed table; typed rows carry their own result.
    typedef struct packed {
        logic    typed;
        t_func   fn;
        t_sector sec;
        t_sector exp_sec;
        t_status exp_status;
    } t_dir_row;

    t_dir_row directed_rows [N_DIRECTED] = '{
        '{1'b1, FN_ALLOC, 13'd0,      13'd0,      ST_OK},
        '{1'b1, FN_ALLOC, 13'd8191,   13'd1,      ST_OK},
        '{1'b1, FN_MARK,  13'd2,      13'd2,      ST_OK},
        '{1'b1, FN_MARK,  13'd2,      13'd2,      ST_ALREADY_USED},
        '{1'b1, FN_ALLOC, 13'h1FFF,   13'd3,      ST_OK},
        '{1'b1, FN_FREE,  13'd1,      13'd1,      ST_OK},
        '{1'b1, FN_FREE,  13'd1,      13'd1,      ST_ALREADY_FREE},
        '{1'b1, FN_ALLOC, 13'd0,      13'd1,      ST_OK},
        '{1'b1, FN_MARK,  13'd8191,   13'd8191,   ST_OK},
        '{1'b1, FN_MARK,  13'd8191,   13'd8191,   ST_ALREADY_USED},
        '{1'b1, FN_FREE,  13'd8191,   13'd8191,   ST_OK},
        '{1'b1, FN_FREE,  13'd8191,   13'd8191,   ST_ALREADY_FREE},
        '{1'b1, FN_FREE,  13'd0,      13'd0,      ST_OK},
        '{1'b1, FN_NOP,   13'h1555,   13'h1555,   ST_OK},
        '{1'b1, FN_NOP,   13'h0AAA,   13'h0AAA,   ST_OK},
        '{1'b0, FN_MARK,  13'd64,     13'd0,      ST_OK},
        '{1'b0, FN_MARK,  13'd63,     13'd0,      ST_OK},
        '{1'b0, FN_ALLOC, 13'h0AAA,   13'd0,      ST_OK},
        '{1'b0, FN_FREE,  13'h0AAA,   13'd0,      ST_OK},
        '{1'b0, FN_MARK,  13'h1555,   13'd0,      ST_OK},
        '{1'b0, FN_ALLOC, 13'h1555,   13'd0,      ST_OK},
        '{1'b0, FN_FREE,  13'd4096,   13'd0,      ST_OK}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    // Shadow copy of the used bitmap and the results still owed by the block.
    logic    shadow_used [TOTAL_SECTORS];
    t_result expected_results [$];
    t_sector owned_sectors [$];
    t_result head_result;

    int unsigned src_idle_pct = 11;
    int unsigned dst_idle_pct = 56;
    int          err_count    = 0;
    int          beats_in     = 0;
    int          results_out  = 0;
    int          idle_cycles  = 0;
    int          n_no_free    = 0;
    int          n_rejected   = 0;

    sector_bitmap_allocator i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_tready),
        .i_s_axis_tdata  (s_tdata),    // [12:0] sector_number
        .i_s_axis_tuser  (s_tuser),    // [1:0] func
        .o_m_axis_tvalid (o_m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_tdata),  // [12:0] result_sector
        .o_m_axis_tuser  (o_m_tuser)   // [1:0] status
    );

    // Clock with a 12 ns period.
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Applies one request to the shadow bitmap and returns its result.
    function automatic t_result predict_bitmap_op(input t_func fn, input t_sector sec);
        t_result r;
        r.sector = sec;
        r.status = ST_OK;
        case (fn)
            FN_ALLOC: begin
                r.sector = '0;
                r.status = ST_NO_FREE;
                for (int s = 0; s < TOTAL_SECTORS; s++) begin
                    if (!shadow_used[s]) begin
                        shadow_used[s] = 1'b1;
                        r.sector = t_sector'(s);
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            FN_MARK: begin
                if (int'(sec) >= TOTAL_SECTORS || shadow_used[sec]) begin
                    r.status = ST_ALREADY_USED;
                end else begin
                    shadow_used[sec] = 1'b1;
                end
            end
            FN_FREE: begin
                if (int'(sec) >= TOTAL_SECTORS || !shadow_used[sec]) begin
                    r.status = ST_ALREADY_FREE;
                end else begin
                    shadow_used[sec] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Biased toward low sectors so that marks and frees meet allocated ones.
    function automatic t_sector pick_sector();
        if ($urandom_range(1) == 0) begin
            return t_sector'($urandom_range(511));
        end
        return t_sector'($urandom_range(8191));
    endfunction

    // Drives one request beat, waits for it to be taken and records its result.
    task automatic send_beat(input t_func fn, input t_sector sec,
                             input logic typed, input t_result typed_res);
        t_result pred;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, sec};
        s_tuser  <= fn;
        @(posedge clk);
        while (!o_s_tready) begin
            @(posedge clk);
        end
        beats_in++;
        pred = predict_bitmap_op(fn, sec);
        if ((fn == FN_ALLOC || fn == FN_MARK) && pred.status == ST_OK) begin
            owned_sectors.push_back(pred.sector);
        end
        if (pred.status == ST_NO_FREE) begin
            n_no_free++;
        end else if (pred.status != ST_OK) begin
            n_rejected++;
        end
        expected_results.push_back(typed ? typed_res : pred);
    endtask

    // One random request: mostly allocations and frees, the frees mostly of owned sectors.
    task automatic send_random_beat();
        int unsigned pick;
        int unsigned idx;
        t_sector     sec;
        pick = $urandom_range(99);
        if (pick < 35) begin
            send_beat(FN_ALLOC, t_sector'($urandom_range(8191)), 1'b0, '0);
        end else if (pick < 65) begin
            if (owned_sectors.size() != 0 && $urandom_range(3) != 0) begin
                idx = $urandom_range(owned_sectors.size() - 1);
                sec = owned_sectors[idx];
                owned_sectors.delete(idx);
            end else begin
                sec = pick_sector();
            end
            send_beat(FN_FREE, sec, 1'b0, '0);
        end else if (pick < 90) begin
            send_beat(FN_MARK, pick_sector(), 1'b0, '0);
        end else begin
            send_beat(FN_NOP, t_sector'($urandom_range(8191)), 1'b0, '0);
        end
    endtask

    // Stimulus: directed table, then random traffic under three idling patterns.
    initial begin
        for (int s = 0; s < TOTAL_SECTORS; s++) begin
            shadow_used[s] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_beat(directed_rows[i].fn, directed_rows[i].sec, directed_rows[i].typed,
                      '{sector: directed_rows[i].exp_sec,
                        status: directed_rows[i].exp_status});
        end
        for (int i = 0; i < N_RANDOM_A; i++) begin
            send_random_beat();
        end

        // Swap the idling of the two sides.
        src_idle_pct = 56;
        dst_idle_pct = 11;
        for (int i = 0; i < N_RANDOM_B; i++) begin
            send_random_beat();
        end

        // No idling on either side.
        src_idle_pct = 0;
        dst_idle_pct = 0;
        for (int i = 0; i < N_RANDOM_C; i++) begin
            send_random_beat();
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d request beats, checked %0d result beats.", beats_in, results_out);
        $display("Seen %0d full-bitmap allocations and %0d rejected marks or frees.",
                 n_no_free, n_rejected);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Receiver: random backpressure on the result channel.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Compares each result beat with the oldest expected result.
    always @(posedge clk) begin
        if (rst_n && o_m_tvalid && m_tready) begin
            results_out++;
            if (expected_results.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS) begin
                    $display("Unexpected result beat: tdata %0d tuser %0d",
                             o_m_tdata, o_m_tuser);
                end
            end else begin
                head_result = expected_results.pop_front();
                if (o_m_tdata !== {3'b000, head_result.sector}
                        || o_m_tuser !== head_result.status) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("Mismatch on result %0d: sector exp %0d got %0d, %s %0d got %0d",
                                 results_out, head_result.sector, o_m_tdata,
                                 "status exp", head_result.status, o_m_tuser);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no beat moved for %0d cycles.", WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
